// File: sv/b64c_pkg.sv
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types, status codes and alphabet functions of the base64url codec.
// ----------------------------------------------------------------------------
`default_nettype none

package b64c_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_BAD_LEN  = 2'd2,
    ST_BAD_TAIL = 2'd3
  } status_t;

  localparam logic [5:0] SEXTET_MASK = 6'h3F;
  localparam logic [7:0] BYTE_MASK   = 8'hFF;

  // Per-string state carried from one request to the next.
  typedef struct packed {
    logic [5:0] pend;
    logic [2:0] cnt;
    logic       skip;
  } str_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       dvalid;
    logic       last;
    status_t    status;
  } result_t;

  localparam result_t RESULT_NONE = '{data: 8'd0, dvalid: 1'b0, last: 1'b0,
                                      status: ST_OK};

  // 6-bit value to base64url character.
  function automatic logic [7:0] encode_char(input logic [5:0] v);
    logic [7:0] v8;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      encode_char = 8'h41 + v8;
    end else if (v < 6'd52) begin
      encode_char = 8'h61 + v8 - 8'd26;
    end else if (v < 6'd62) begin
      encode_char = 8'h30 + v8 - 8'd52;
    end else if (v == 6'd62) begin
      encode_char = 8'h2D;
    end else begin
      encode_char = 8'h5F;
    end
  endfunction

  // Character to {ok, 6-bit value}; ok low for anything outside the alphabet.
  function automatic logic [6:0] decode_char(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
      decode_char = {1'b1, t[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'h61 + 8'd26;
      decode_char = {1'b1, t[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30 + 8'd52;
      decode_char = {1'b1, t[5:0]};
    end else if (c == 8'h2D) begin
      decode_char = {1'b1, 6'd62};
    end else if (c == 8'h5F) begin
      decode_char = {1'b1, 6'd63};
    end else begin
      decode_char = 7'd0;
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/b64c_step.sv
// ----------------------------------------------------------------------------
// b64c_step
// One request of encode or decode: up to two results and the next state.
// ----------------------------------------------------------------------------
`default_nettype none

module b64c_step
  import b64c_pkg::*;
(
  input  wire logic       dir,
  input  wire str_state_t st,
  input  wire logic [7:0] byte_in,
  input  wire logic       last_in,
  output logic [1:0]      nres,
  output result_t         res0,
  output result_t         res1,
  output str_state_t      st_nxt
);

  logic [6:0]  mask7;
  logic [5:0]  pend_m;
  logic [2:0]  cnt_c;
  logic [13:0] eacc;
  logic [3:0]  n1;
  logic [3:0]  nrem;
  logic [5:0]  sx;
  logic [6:0]  dc;
  logic [11:0] dacc;
  logic [3:0]  dn;
  logic [6:0]  rmask7;
  logic [5:0]  rem;
  logic [13:0] sh;
  logic [11:0] dsh;

  always_comb begin
    nres   = 2'd0;
    res0   = RESULT_NONE;
    res1   = RESULT_NONE;
    st_nxt = st;
    mask7  = 7'd0;
    pend_m = 6'd0;
    cnt_c  = 3'd0;
    eacc   = 14'd0;
    n1     = 4'd0;
    nrem   = 4'd0;
    sx     = 6'd0;
    dc     = 7'd0;
    dacc   = 12'd0;
    dn     = 4'd0;
    rmask7 = 7'd0;
    rem    = 6'd0;
    sh     = 14'd0;
    dsh    = 12'd0;

    if (st.skip) begin
      // dropping the rest of a failed string
      st_nxt.skip = !last_in;
    end else if (!dir) begin
      cnt_c  = (st.cnt > 3'd4) ? 3'd0 : st.cnt;
      mask7  = (7'd1 << cnt_c) - 7'd1;
      pend_m = st.pend & mask7[5:0];
      eacc   = {pend_m, byte_in};
      n1     = {1'b0, cnt_c} + 4'd2;
      sh     = eacc >> n1;
      res0   = '{data: encode_char(sh[5:0] & SEXTET_MASK), dvalid: 1'b1,
                 last: 1'b0, status: ST_OK};
      nres   = 2'd1;
      nrem   = n1;
      if (n1 >= 4'd6) begin
        sh   = eacc >> (n1 - 4'd6);
        res1 = '{data: encode_char(sh[5:0]), dvalid: 1'b1, last: 1'b0,
                 status: ST_OK};
        nres = 2'd2;
        nrem = n1 - 4'd6;
      end
      rmask7 = (7'd1 << nrem) - 7'd1;
      if (last_in) begin
        if (nrem != 4'd0 && nres == 2'd1) begin
          // zero-filled flush of the leftover bits
          sx   = eacc[5:0] << (4'd6 - nrem);
          res1 = '{data: encode_char(sx), dvalid: 1'b1, last: 1'b0,
                   status: ST_OK};
          nres = 2'd2;
        end
        if (nres == 2'd2) begin
          res1.last = 1'b1;
        end else begin
          res0.last = 1'b1;
        end
        st_nxt = '0;
      end else begin
        st_nxt.pend = eacc[5:0] & rmask7[5:0];
        st_nxt.cnt  = nrem[2:0];
        st_nxt.skip = 1'b0;
      end
    end else begin
      dc = decode_char(byte_in);
      if (!dc[6]) begin
        res0   = '{data: 8'd0, dvalid: 1'b0, last: 1'b1, status: ST_BAD_CHAR};
        nres   = 2'd1;
        st_nxt = '0;
        st_nxt.skip = !last_in;
      end else begin
        cnt_c  = (st.cnt > 3'd6) ? 3'd0 : st.cnt;
        mask7  = (7'd1 << cnt_c) - 7'd1;
        pend_m = st.pend & mask7[5:0];
        dacc   = {pend_m, dc[5:0]};
        dn     = {1'b0, cnt_c} + 4'd6;
        nrem   = dn;
        if (dn >= 4'd8) begin
          dsh  = dacc >> (dn - 4'd8);
          res0 = '{data: dsh[7:0] & BYTE_MASK, dvalid: 1'b1, last: 1'b0,
                   status: ST_OK};
          nres = 2'd1;
          nrem = dn - 4'd8;
        end
        rmask7 = (7'd1 << nrem) - 7'd1;
        rem    = dacc[5:0] & rmask7[5:0];
        if (!last_in) begin
          st_nxt.pend = rem;
          st_nxt.cnt  = nrem[2:0];
          st_nxt.skip = 1'b0;
        end else begin
          st_nxt = '0;
          if (nrem >= 4'd6 || (nrem != 4'd0 && rem != 6'd0)) begin
            // status-only result behind any byte already made
            if (nres == 2'd1) begin
              res1 = '{data: 8'd0, dvalid: 1'b0, last: 1'b1,
                       status: (nrem >= 4'd6) ? ST_BAD_LEN : ST_BAD_TAIL};
              nres = 2'd2;
            end else begin
              res0 = '{data: 8'd0, dvalid: 1'b0, last: 1'b1,
                       status: (nrem >= 4'd6) ? ST_BAD_LEN : ST_BAD_TAIL};
              nres = 2'd1;
            end
          end else if (nres == 2'd1) begin
            res0.last = 1'b1;
          end else begin
            res0 = '{data: 8'd0, dvalid: 1'b0, last: 1'b1, status: ST_OK};
            nres = 2'd1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/base64url_stream_codec.sv
// ----------------------------------------------------------------------------
// base64url_stream_codec
// Unpadded base64url encoder/decoder over a stream of strings.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_wr_en/cfg_wr_data set the direction (0 encode, 1 decode) and drop any
//   string in progress; write only while the block is idle.
//   Input requests (in_valid/in_ready) carry one byte or character and a
//   last flag closing the string. Output requests (out_res_valid/
//   out_res_ready) carry a character or byte (out_valid = 1) or a
//   status-only result (out_valid = 0, out_status nonzero on error).
//   The final result of every string has out_last set.
// Flow: an accepted request sits in the input register, is processed from
//   there once the result buffer is free, and its results are registered into it.
// Throughput: one request per cycle when it makes zero or one result and
//   out_res_ready is high; two results hold back the next request until
//   the second one reaches the head: one port drains the two-entry buffer.
// Reset (rst_n low, synchronous): direction encode, string state cleared,
//   both registers empty.
// Stall: when out_res_ready is low the result buffer holds, processing stops
//   and in_ready drops once the input register is also full.
// ----------------------------------------------------------------------------
`default_nettype none

module base64url_stream_codec
  import b64c_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_res_valid,
  input  wire logic       out_res_ready,
  output logic [7:0]      out_byte,
  output logic            out_valid,
  output logic            out_last,
  output logic [1:0]      out_status
);

  logic       dir_r;
  str_state_t st_r;
  str_state_t st_nxt;

  // input register
  logic       item_vld_r;
  logic [7:0] item_byte_r;
  logic       item_last_r;

  // result buffer: head entry on the port, second entry behind it
  result_t    head_r;
  logic       head_vld_r;
  result_t    hold_r;
  logic       hold_vld_r;

  logic [1:0] nres;
  result_t    res0;
  result_t    res1;
  logic       buf_free;
  logic       proc;

  b64c_step u_step (
    .dir     (dir_r),
    .st      (st_r),
    .byte_in (item_byte_r),
    .last_in (item_last_r),
    .nres    (nres),
    .res0    (res0),
    .res1    (res1),
    .st_nxt  (st_nxt)
  );

  // buffer frees when empty or its last entry leaves this cycle
  assign buf_free = !head_vld_r || (out_res_ready && !hold_vld_r);
  assign proc     = item_vld_r && buf_free;
  assign in_ready = !item_vld_r || buf_free;

  assign out_res_valid = head_vld_r;
  assign out_byte      = head_r.data;
  assign out_valid     = head_r.dvalid;
  assign out_last      = head_r.last;
  assign out_status    = head_r.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
      st_r  <= '0;
    end else if (cfg_wr_en) begin
      dir_r <= cfg_wr_data;
      st_r  <= '0;
    end else if (proc) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_vld_r <= 1'b1;
    end else if (proc) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_byte_r <= in_byte;
      item_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      hold_vld_r <= 1'b0;
    end else begin
      if (head_vld_r && out_res_ready) begin
        head_vld_r <= hold_vld_r;
        hold_vld_r <= 1'b0;
      end
      if (proc && nres != 2'd0) begin
        head_vld_r <= 1'b1;
        hold_vld_r <= (nres == 2'd2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc && nres != 2'd0) begin
      head_r <= res0;
      hold_r <= res1;
    end else if (head_vld_r && out_res_ready && hold_vld_r) begin
      head_r <= hold_r;
    end
  end

endmodule

`default_nettype wire
